[rtl/core/ats_pkg.sv]
// Shared types and constants for the alarm table with snooze.
package ats_pkg;

    // Field widths
    localparam int KIND_W   = 3;
    localparam int MIN_W    = 11;
    localparam int WDAY_W   = 3;
    localparam int SLOT_W   = 4;
    localparam int REP_W    = 7;
    localparam int METH_W   = 8;
    localparam int ALARM_W  = 5;
    localparam int STEP_W   = 9;
    localparam int SNZ_W    = 4;
    localparam int DMASK_W  = 8;

    // Highest number of slots the slot field can reach
    localparam int SLOTS    = 2 ** SLOT_W;

    // Stream payload widths (whole bytes)
    localparam int IN_W     = 48;
    localparam int OUT_W    = 24;

    // Timing constants
    localparam logic [STEP_W-1:0] RING_LIMIT     = 9'd300;
    localparam logic [SNZ_W-1:0]  SNOOZE_MINUTES = 4'd9;
    localparam logic [STEP_W-1:0] SNOOZE_SAT     = 9'd8;

    // Item kinds carried in tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 3'd0,
        KIND_DISMISS = 3'd1,
        KIND_SNOOZE  = 3'd2,
        KIND_WRITE   = 3'd3,
        KIND_SET_EN  = 3'd4,
        KIND_READ    = 3'd5
    } t_kind;

    // Input tdata layout, lowest field last
    typedef struct packed {
        logic [2:0]        pad;
        logic [METH_W-1:0] entry_method;
        logic [REP_W-1:0]  entry_repeat;
        logic              entry_enabled;
        logic [MIN_W-1:0]  entry_time;
        logic [SLOT_W-1:0] slot;
        logic [WDAY_W-1:0] weekday;
        logic [MIN_W-1:0]  time_min;
    } t_in_data;

    // Output tdata layout, lowest field last
    typedef struct packed {
        logic               pad;
        logic               changed;
        logic [METH_W-1:0]  active_method;
        logic [STEP_W-1:0]  ring_step;
        logic [ALARM_W-1:0] active_alarm;
    } t_out_data;

    // Stored part of one table entry
    typedef struct packed {
        logic [MIN_W-1:0]  time_min;
        logic [REP_W-1:0]  repeat_mask;
        logic [METH_W-1:0] method;
    } t_entry;

    // Entry as read back for a scan
    typedef struct packed {
        logic   enabled;
        t_entry data;
    } t_entry_rd;

    // Table write request from the sequencer
    typedef struct packed {
        logic   wr_entry;
        logic   set_en;
        logic   en_val;
        t_entry data;
    } t_tbl_req;

endpackage

[rtl/core/alarm_table_with_snooze_unit.sv]
// Sequence: a tick that scans the table passes through ST_SCAN, ST_DRAIN and ST_FINISH
// before its result is registered; every other item goes straight to ST_FINISH.
// Throughput: one item at a time; a scanning tick holds the block while the single
// compare unit steps through the table one entry per cycle.
// Reset: synchronous, active low; clears status, the output valid flag and all table
// valid/enable bits, so the block is ready right after reset.
module alarm_table_with_snooze_unit #(
    parameter int ALARMS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // time_min[10:0], weekday[13:11], slot[17:14], entry_time[28:18],
    // entry_enabled[29], entry_repeat[36:30], entry_method[44:37], zero[47:45]
    input  logic [ats_pkg::IN_W-1:0]    s_tdata,
    // kind[2:0]
    input  logic [ats_pkg::KIND_W-1:0]  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // active_alarm[4:0], ring_step[13:5], active_method[21:14], changed[22], zero[23]
    output logic [ats_pkg::OUT_W-1:0]   m_tdata
);
    import ats_pkg::*;

    // Slots beyond the slot field's reach can never be written, so are not stored
    localparam int DEPTH = (ALARMS < SLOTS) ? ALARMS : SLOTS;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACT_W = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_ADDR = IW'(DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_kind               r_kind, n_kind;
    logic [ACT_W-1:0]    r_act, n_act;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [SNZ_W-1:0]    r_snooze, n_snooze;
    logic                r_change, n_change;
    logic [MIN_W-1:0]    r_last, n_last;
    logic [METH_W-1:0]   r_meth, n_meth;
    logic [MIN_W-1:0]    r_now, n_now;
    logic [DMASK_W-1:0]  r_daymask, n_daymask;
    logic [IW-1:0]       r_addr, n_addr;
    logic                r_rd_vld;
    logic [IW-1:0]       r_rd_idx;
    logic                r_m_valid, n_m_valid;
    t_out_data           r_m_data, n_m_data;

    t_in_data            in_d;
    t_kind               in_kind;
    logic                accept;
    logic                slot_ok;
    t_tbl_req            tbl_req;
    t_entry_rd           rd_entry;
    logic                rd_en;
    logic                hit;

    assign in_d    = t_in_data'(s_tdata);
    assign in_kind = t_kind'(s_tuser);
    assign slot_ok = ({1'b0, in_d.slot} < (SLOT_W + 1)'(DEPTH));

    // Take a new item only when idle and the output register is free or draining
    assign s_tready = (r_state == ST_IDLE) && (!r_m_valid || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign rd_en    = (r_state == ST_SCAN);

    ats_table #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tbl_req),
        .i_wr_addr (IW'(in_d.slot)),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd      (rd_entry)
    );

    ats_match u_match (
        .i_entry   (rd_entry),
        .i_now     (r_now),
        .i_daymask (r_daymask),
        .o_hit     (hit)
    );

    // Sequencer and status update
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_act     = r_act;
        n_step    = r_step;
        n_snooze  = r_snooze;
        n_change  = r_change;
        n_last    = r_last;
        n_meth    = r_meth;
        n_now     = r_now;
        n_daymask = r_daymask;
        n_addr    = r_addr;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;

        tbl_req                  = '0;
        tbl_req.en_val           = in_d.entry_enabled;
        tbl_req.data.time_min    = in_d.entry_time;
        tbl_req.data.repeat_mask = in_d.entry_repeat;
        tbl_req.data.method      = in_d.entry_method;

        if (r_m_valid && m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_kind  = in_kind;
                    n_state = ST_FINISH;
                    unique case (in_kind)
                        KIND_TICK: begin
                            if (in_d.time_min != r_last) begin
                                n_last = in_d.time_min;
                                if (r_snooze != '0) begin
                                    n_snooze = r_snooze - 1'b1;
                                    if (r_snooze == SNZ_W'(1)) begin
                                        n_change = 1'b1;
                                        n_step   = STEP_W'(1);
                                    end
                                end else if (r_act == '0) begin
                                    n_now     = in_d.time_min;
                                    n_daymask = DMASK_W'(1) << in_d.weekday;
                                    n_addr    = '0;
                                    n_state   = ST_SCAN;
                                end else begin
                                    if (r_step > RING_LIMIT) begin
                                        n_act  = '0;
                                        n_step = '0;
                                    end else begin
                                        n_step = r_step + 1'b1;
                                    end
                                    n_change = 1'b1;
                                end
                            end
                        end
                        KIND_DISMISS: begin
                            n_act    = '0;
                            n_step   = '0;
                            n_change = 1'b1;
                        end
                        KIND_SNOOZE: begin
                            n_snooze = (r_step >= SNOOZE_SAT) ? SNZ_W'(1)
                                     : SNOOZE_MINUTES - r_step[SNZ_W-1:0];
                            n_step   = '0;
                            n_change = 1'b1;
                        end
                        KIND_WRITE: begin
                            if (slot_ok) begin
                                tbl_req.wr_entry = 1'b1;
                                // Rewriting the ringing entry updates its reported method
                                if (r_act != '0
                                    && r_act == ACT_W'({1'b0, in_d.slot} + 5'd1)) begin
                                    n_meth = in_d.entry_method;
                                end
                            end
                        end
                        KIND_SET_EN: begin
                            tbl_req.set_en = slot_ok;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                n_m_valid              = 1'b1;
                n_m_data.pad           = 1'b0;
                n_m_data.changed       = r_change;
                n_m_data.active_alarm  = ALARM_W'(r_act);
                n_m_data.ring_step     = (r_act != '0) ? r_step : '0;
                n_m_data.active_method = (r_act != '0) ? r_meth : '0;
                if (r_kind == KIND_READ) begin
                    n_change = 1'b0;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Scan result: later matches overwrite earlier ones
        if (r_rd_vld && hit) begin
            n_act    = ACT_W'({1'b0, r_rd_idx} + 1'b1);
            n_step   = STEP_W'(1);
            n_snooze = '0;
            n_change = 1'b1;
            n_meth   = rd_entry.data.method;
        end
    end

    // Control and status registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_kind    <= KIND_TICK;
            r_act     <= '0;
            r_step    <= '0;
            r_snooze  <= '0;
            r_change  <= 1'b0;
            r_last    <= '0;
            r_meth    <= '0;
            r_rd_vld  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_kind    <= n_kind;
            r_act     <= n_act;
            r_step    <= n_step;
            r_snooze  <= n_snooze;
            r_change  <= n_change;
            r_last    <= n_last;
            r_meth    <= n_meth;
            r_rd_vld  <= rd_en;
            r_m_valid <= n_m_valid;
        end
    end

    // Scan context and output payload
    always_ff @(posedge i_clk) begin
        r_now     <= n_now;
        r_daymask <= n_daymask;
        r_addr    <= n_addr;
        r_rd_idx  <= r_addr;
        r_m_data  <= n_m_data;
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = OUT_W'(r_m_data);

endmodule

[rtl/core/ats_table.sv]
// Alarm table: entry memory with registered read, per-entry valid and enable bits.
module ats_table #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ats_pkg::t_tbl_req  i_req,
    input  logic [IW-1:0]      i_wr_addr,
    input  logic               i_rd_en,
    input  logic [IW-1:0]      i_rd_addr,
    output ats_pkg::t_entry_rd o_rd
);
    import ats_pkg::*;

    t_entry           r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DEPTH-1:0] r_enable;
    t_entry_rd        r_rd;

    // Entry storage, no reset; unwritten entries masked by valid bit
    always_ff @(posedge i_clk) begin
        if (i_req.wr_entry) begin
            r_mem[i_wr_addr] <= i_req.data;
        end
    end

    // Valid and enable bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_enable <= '0;
        end else begin
            if (i_req.wr_entry) begin
                r_valid[i_wr_addr]  <= 1'b1;
                r_enable[i_wr_addr] <= i_req.en_val;
            end else if (i_req.set_en) begin
                r_enable[i_wr_addr] <= i_req.en_val;
            end
        end
    end

    // Registered scan read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd.enabled <= r_enable[i_rd_addr];
            r_rd.data    <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd = r_rd;

endmodule

[rtl/core/ats_match.sv]
// Compare unit: tests one table entry against the current minute and weekday.
module ats_match (
    input  ats_pkg::t_entry_rd             i_entry,
    input  logic [ats_pkg::MIN_W-1:0]      i_now,
    input  logic [ats_pkg::DMASK_W-1:0]    i_daymask,
    output logic                           o_hit
);
    import ats_pkg::*;

    logic day_ok;

    // Zero repeat mask fires every day; weekday seven matches no mask bit
    assign day_ok = (i_entry.data.repeat_mask == '0)
                 || (({1'b0, i_entry.data.repeat_mask} & i_daymask) != '0);

    assign o_hit = i_entry.enabled && day_ok && (i_entry.data.time_min == i_now);

endmodule

[rtl/core/ats_checker.sv]
// Port-level checks for the alarm table with snooze, bound to the top level.
module ats_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [ats_pkg::OUT_W-1:0]   m_tdata
);
    import ats_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Input is taken only when the output register is free or draining
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !m_tvalid || m_tready)
        else $error("input ready while result blocked");

    // One item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // No alarm means no step count and no method
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata[4:0] == 5'd0) |-> (m_tdata[21:5] == 17'd0))
        else $error("status fields set without active alarm");

    // Ringing count never passes one beyond the limit
    a_step_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[13:5] <= RING_LIMIT + 9'd1))
        else $error("ring step out of range");

endmodule

bind alarm_table_with_snooze_unit ats_checker u_ats_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
